@@ rtl/core/component_mask_table_assert.svh @@
// ---------------------------------------------------------------------------
// component_mask_table_assert.svh
// Assertion macros used by the component mask table port checker (cmt_checker).
// ---------------------------------------------------------------------------
`ifndef COMPONENT_MASK_TABLE_ASSERT_SVH
`define COMPONENT_MASK_TABLE_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define CMT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define CMT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/cmt_pkg.sv @@
// ---------------------------------------------------------------------------
// cmt_pkg
// Types and field layout of the component mask table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cmt_pkg;

	localparam int KIND_W = 3;
	localparam int ID_W   = 12;
	localparam int COMP_W = 6;
	localparam int MASK_W = 64;

	// input transaction layout
	localparam int IN_KIND_LSB = 0;
	localparam int IN_ENT_LSB  = IN_KIND_LSB + KIND_W;
	localparam int IN_COMP_LSB = IN_ENT_LSB + ID_W;
	localparam int IN_MASK_LSB = IN_COMP_LSB + COMP_W;
	localparam int IN_USED_W   = IN_MASK_LSB + MASK_W;
	localparam int IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;

	// output transaction layout
	localparam int OUT_STATUS_LSB = 0;
	localparam int OUT_ENT_LSB    = OUT_STATUS_LSB + 1;
	localparam int OUT_HIT_LSB    = OUT_ENT_LSB + ID_W;
	localparam int OUT_MASK_LSB   = OUT_HIT_LSB + 1;
	localparam int OUT_USED_W     = OUT_MASK_LSB + MASK_W;
	localparam int OUT_TDATA_W    = ((OUT_USED_W + 7) / 8) * 8;
	localparam int OUT_PAD_W      = OUT_TDATA_W - OUT_USED_W;

	typedef enum logic [KIND_W-1:0] {
		KIND_ALLOC   = 3'd0,
		KIND_SET     = 3'd1,
		KIND_CLEAR   = 3'd2,
		KIND_DESTROY = 3'd3,
		KIND_HAS     = 3'd4,
		KIND_QUERY   = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

endpackage

@@ rtl/core/cmt_ram.sv @@
// ---------------------------------------------------------------------------
// cmt_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cmt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ rtl/core/component_mask_table.sv @@
// ---------------------------------------------------------------------------
// component_mask_table
// Per-entity 64-bit component masks with allocate, set, clear, destroy,
// has-test and find-next query operations.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one command per transaction (kind, entity, component,
//   mask); m_axis returns exactly one result per command (status,
//   entity_out, hit, mask_now), in command order.
//   Masks live in one NUM_ENTITIES x 64 synchronous RAM. A command is taken
//   in ST_IDLE (read issued) and finished in ST_EXEC (modify, write back,
//   result loaded), which waits while the output register is still full.
//   Query reads one entity per cycle from the start index; it examines at
//   least one entity even when the start index is at or beyond the next id,
//   and at most next id minus start.
//   Only one command is in flight, so a write back always lands before the
//   next read and no forwarding is needed.
//   After reset the RAM is swept to zero, one entry a cycle; s_axis_tready
//   stays low until the sweep ends. The id counter restarts at FIRST_ID.
//   The result sits in an output register; a new command is accepted while
//   it waits. If the receiver still stalls when the next result is ready,
//   that command holds in its final cycle and no further command is taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module component_mask_table #(
	parameter int NUM_ENTITIES = 4096,
	parameter int FIRST_ID     = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// kind, entity, component, mask
	input  logic [cmt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// status, entity_out, hit, mask_now
	output logic [cmt_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	import cmt_pkg::*;

	localparam int AW = $clog2(NUM_ENTITIES);
	localparam int NW = AW + 1;
	localparam logic [NW-1:0] NUM_N  = NW'(NUM_ENTITIES);
	localparam logic [AW-1:0] LAST_A = AW'(NUM_ENTITIES - 1);

	state_t state_q, state_d;

	kind_t             in_kind;
	logic [ID_W-1:0]   in_entity;
	logic [COMP_W-1:0] in_comp;
	logic [MASK_W-1:0] in_mask;
	logic              accept;

	kind_t             kind_q;
	logic [COMP_W-1:0] comp_q;
	logic [MASK_W-1:0] need_q;
	logic              inside_q;
	logic [NW-1:0]     scan_q;
	logic [NW-1:0]     next_q;
	logic [AW-1:0]     clr_q;

	logic                   out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;
	logic                   out_free;

	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [MASK_W-1:0] rd_data;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [MASK_W-1:0] wr_data;

	logic              op_wr;
	logic [AW-1:0]     op_addr;
	logic [MASK_W-1:0] op_data;
	logic              done;
	logic              step;
	logic              finish;
	logic              bump;
	logic              covers;
	logic [MASK_W-1:0] comp_bit;
	logic [NW-1:0]     scan_nx;

	logic              res_status;
	logic [ID_W-1:0]   res_ent;
	logic              res_hit;
	logic [MASK_W-1:0] res_now;

	assign in_kind   = kind_t'(s_axis_tdata[IN_KIND_LSB +: KIND_W]);
	assign in_entity = s_axis_tdata[IN_ENT_LSB +: ID_W];
	assign in_comp   = s_axis_tdata[IN_COMP_LSB +: COMP_W];
	assign in_mask   = s_axis_tdata[IN_MASK_LSB +: MASK_W];

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;
	assign covers   = (rd_data & need_q) == need_q;
	assign comp_bit = MASK_W'(1) << comp_q;
	assign scan_nx  = scan_q + 1'b1;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	cmt_ram #(
		.WIDTH(MASK_W),
		.DEPTH(NUM_ENTITIES)
	) u_mask_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// operation decode on the read data
	always_comb begin
		op_wr      = 1'b0;
		op_addr    = AW'(scan_q);
		op_data    = '0;
		done       = 1'b0;
		step       = 1'b0;
		bump       = 1'b0;
		res_status = 1'b0;
		res_ent    = '0;
		res_hit    = 1'b0;
		res_now    = '0;
		case (kind_q)
			KIND_ALLOC: begin
				done = 1'b1;
				if (next_q >= NUM_N) begin
					res_status = 1'b1;
				end else begin
					op_wr   = 1'b1;
					op_addr = next_q[AW-1:0];
					res_ent = ID_W'(next_q);
					bump    = 1'b1;
				end
			end
			KIND_SET: begin
				done = 1'b1;
				if (inside_q) begin
					op_wr   = 1'b1;
					op_data = rd_data | comp_bit;
					res_now = rd_data | comp_bit;
				end
			end
			KIND_CLEAR: begin
				done = 1'b1;
				if (inside_q) begin
					op_wr   = 1'b1;
					op_data = rd_data & ~comp_bit;
					res_now = rd_data & ~comp_bit;
				end
			end
			KIND_DESTROY: begin
				done  = 1'b1;
				op_wr = inside_q;
			end
			KIND_HAS: begin
				done = 1'b1;
				if (inside_q) begin
					res_now = rd_data;
					res_hit = covers;
				end
			end
			KIND_QUERY: begin
				if (!inside_q || scan_q >= next_q) begin
					done = 1'b1;
				end else if (covers) begin
					done    = 1'b1;
					res_hit = 1'b1;
					res_ent = ID_W'(scan_q);
				end else if (scan_nx >= next_q) begin
					done = 1'b1;
				end else begin
					step = 1'b1;
				end
			end
			default: begin
				done = 1'b1;
			end
		endcase
	end

	// next state and memory ports
	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		rd_en         = 1'b0;
		rd_addr       = AW'(in_entity);
		wr_en         = 1'b0;
		wr_addr       = op_addr;
		wr_data       = op_data;
		finish        = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
				if (clr_q == LAST_A) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					rd_en   = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (step) begin
					rd_en   = 1'b1;
					rd_addr = scan_nx[AW-1:0];
				end else if (done && out_free) begin
					finish  = 1'b1;
					wr_en   = op_wr;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			next_q      <= NW'(FIRST_ID);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (finish && bump) begin
				next_q <= next_q + 1'b1;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= in_kind;
			comp_q   <= in_comp;
			need_q   <= in_mask;
			inside_q <= 32'(in_entity) < 32'(NUM_ENTITIES);
			scan_q   <= NW'(in_entity);
		end else if (step) begin
			scan_q <= scan_nx;
		end
		if (finish) begin
			out_data_q <= {OUT_PAD_W'(1'b0), res_now, res_hit, res_ent, res_status};
		end
	end

endmodule

@@ rtl/core/cmt_checker.sv @@
// ---------------------------------------------------------------------------
// cmt_checker
// Port-level checks of the component mask table, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "component_mask_table_assert.svh"

module cmt_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic [cmt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [cmt_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	import cmt_pkg::*;

	logic in_xact;
	logic full_res;
	logic full_clean;

	assign in_xact    = s_axis_tvalid && s_axis_tready;
	assign full_res   = m_axis_tvalid && m_axis_tdata[OUT_STATUS_LSB];
	assign full_clean = (m_axis_tdata[OUT_ENT_LSB +: ID_W] == '0)
		&& !m_axis_tdata[OUT_HIT_LSB] && (m_axis_tdata[OUT_MASK_LSB +: MASK_W] == '0);

	`CMT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")
	`CMT_ASSERT_NEXT(a_busy_after_accept, in_xact, !s_axis_tready, "command taken while one is in flight")
	`CMT_ASSERT_NOW(a_result_from_cmd, $rose(m_axis_tvalid), $past(!s_axis_tready), "result without a command in flight")
	`CMT_ASSERT_NOW(a_full_clean, full_res, full_clean, "table-full result carries data")

endmodule

bind component_mask_table cmt_checker u_cmt_checker (.*);

@@ verif/component_mask_table_checker.sv @@
// ---------------------------------------------------------------------------
// component_mask_table_checker
// Watches both stream channels of the component mask table. Every accepted
// command runs through a local copy of the mask store and the id counter;
// the resulting answer is queued and compared field by field with the next
// result the table returns.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module component_mask_table_checker #(
	parameter int NUM_ENTITIES = 4096,
	parameter int FIRST_ID     = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	input  logic                            s_axis_tready,
	// kind, entity, component, mask
	input  logic [cmt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// status, entity_out, hit, mask_now
	input  logic [cmt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	output int                              errors,
	output int                              pending,
	output int                              checked,
	output int                              hits,
	output int                              fulls
);

	import cmt_pkg::*;

	// status sits in the lowest bit, as on m_axis_tdata
	typedef struct packed {
		logic [MASK_W-1:0] mask_now;
		logic              hit;
		logic [ID_W-1:0]   entity_out;
		logic              status;
	} table_answer_t;

	logic [MASK_W-1:0] mask_tbl [NUM_ENTITIES];
	int                next_id;
	table_answer_t     answers_due [$];
	table_answer_t     got_answer;
	table_answer_t     want_answer;

	task automatic report(input string field, input logic [MASK_W-1:0] got,
			input logic [MASK_W-1:0] want);
		$display("%0t ns: %s mismatch, got %0h, expected %0h", $time, field, got, want);
		errors++;
	endtask

	function automatic table_answer_t predict_answer(input logic [KIND_W-1:0] kind,
			input logic [ID_W-1:0] ent, input logic [COMP_W-1:0] comp,
			input logic [MASK_W-1:0] need);
		table_answer_t a;
		int            e;
		a = '0;
		case (kind)
			KIND_ALLOC: begin
				if (next_id >= NUM_ENTITIES) begin
					a.status = 1'b1;
				end else begin
					mask_tbl[next_id] = '0;
					a.entity_out = next_id[ID_W-1:0];
					next_id++;
				end
			end
			KIND_SET: begin
				if (int'(ent) < NUM_ENTITIES) begin
					mask_tbl[ent] = mask_tbl[ent] | (64'd1 << comp);
					a.mask_now = mask_tbl[ent];
				end
			end
			KIND_CLEAR: begin
				if (int'(ent) < NUM_ENTITIES) begin
					mask_tbl[ent] = mask_tbl[ent] & ~(64'd1 << comp);
					a.mask_now = mask_tbl[ent];
				end
			end
			KIND_DESTROY: begin
				if (int'(ent) < NUM_ENTITIES)
					mask_tbl[ent] = '0;
			end
			KIND_HAS: begin
				if (int'(ent) < NUM_ENTITIES) begin
					a.mask_now = mask_tbl[ent];
					a.hit = ((mask_tbl[ent] & need) == need);
				end
			end
			KIND_QUERY: begin
				for (e = int'(ent); e < next_id && e < NUM_ENTITIES && !a.hit; e++) begin
					if ((mask_tbl[e] & need) == need) begin
						a.hit = 1'b1;
						a.entity_out = e[ID_W-1:0];
					end
				end
			end
			default: ;
		endcase
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_ENTITIES; i++)
				mask_tbl[i] = '0;
			next_id = FIRST_ID;
			answers_due.delete();
			errors = 0;
			checked = 0;
			hits = 0;
			fulls = 0;
			pending <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got_answer = table_answer_t'(m_axis_tdata[OUT_USED_W-1:0]);
				checked++;
				if (answers_due.size() == 0) begin
					report("result without command, entity_out",
						MASK_W'(got_answer.entity_out), '0);
				end else begin
					want_answer = answers_due.pop_front();
					if (got_answer.status !== want_answer.status)
						report("status", MASK_W'(got_answer.status),
							MASK_W'(want_answer.status));
					if (got_answer.entity_out !== want_answer.entity_out)
						report("entity_out", MASK_W'(got_answer.entity_out),
							MASK_W'(want_answer.entity_out));
					if (got_answer.hit !== want_answer.hit)
						report("hit", MASK_W'(got_answer.hit), MASK_W'(want_answer.hit));
					if (got_answer.mask_now !== want_answer.mask_now)
						report("mask_now", got_answer.mask_now, want_answer.mask_now);
					if (want_answer.hit)
						hits++;
					if (want_answer.status)
						fulls++;
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				answers_due.push_back(predict_answer(
					s_axis_tdata[IN_KIND_LSB +: KIND_W],
					s_axis_tdata[IN_ENT_LSB +: ID_W],
					s_axis_tdata[IN_COMP_LSB +: COMP_W],
					s_axis_tdata[IN_MASK_LSB +: MASK_W]));
			pending <= answers_due.size();
		end
	end

endmodule

@@ verif/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench
// Drives the component mask table with a short directed sequence (unallocated
// and low ids, empty and full masks, find-next misses, spare kinds), then
// random commands focused on recently allocated entities in three rounds.
// Sender and receiver stall at random with changing mixes; a checker module
// predicts and compares.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	import cmt_pkg::*;

	localparam int NUM_ENTITIES = 4096;
	localparam int FIRST_ID     = 256;
	localparam int WINDOW       = 48;

	localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
	localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	int snd_idle = 35;
	int rcv_idle = 45;
	int next_guess = FIRST_ID;
	int sent = 0;
	int queries_sent = 0;
	int errors, pending, checked, hits, fulls;

	always #10 clk = ~clk;

	component_mask_table #(
		.NUM_ENTITIES(NUM_ENTITIES),
		.FIRST_ID(FIRST_ID)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	component_mask_table_checker #(
		.NUM_ENTITIES(NUM_ENTITIES),
		.FIRST_ID(FIRST_ID)
	) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.errors(errors),
		.pending(pending),
		.checked(checked),
		.hits(hits),
		.fulls(fulls)
	);

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99, 0) >= rcv_idle);
	end

	task automatic send_command(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] ent,
			input logic [COMP_W-1:0] comp, input logic [MASK_W-1:0] mask);
		logic [IN_TDATA_W-1:0] word;
		word = '0;
		word[IN_KIND_LSB +: KIND_W] = kind;
		word[IN_ENT_LSB +: ID_W] = ent;
		word[IN_COMP_LSB +: COMP_W] = comp;
		word[IN_MASK_LSB +: MASK_W] = mask;
		while ($urandom_range(99, 0) < snd_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= word;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sent++;
		if (kind == KIND_ALLOC && next_guess < NUM_ENTITIES)
			next_guess++;
		if (kind == KIND_QUERY)
			queries_sent++;
	endtask

	// mostly the newest allocated entities, so their masks fill up
	function automatic logic [ID_W-1:0] pick_entity();
		int r;
		int lo;
		r = $urandom_range(99, 0);
		if (next_guess > FIRST_ID && r < 80) begin
			lo = (next_guess - WINDOW > FIRST_ID) ? next_guess - WINDOW : FIRST_ID;
			return ID_W'($urandom_range(next_guess - 1, lo));
		end
		if (r < 90)
			return ID_W'($urandom_range(NUM_ENTITIES - 1, 0));
		return ID_W'($urandom_range(FIRST_ID - 1, 0));
	endfunction

	function automatic logic [MASK_W-1:0] pick_mask();
		logic [MASK_W-1:0] m;
		int                r;
		m = '0;
		r = $urandom_range(99, 0);
		if (r < 20)
			m = '0;
		else if (r < 70)
			repeat ($urandom_range(3, 1)) m[$urandom_range(7, 0)] = 1'b1;
		else if (r < 85)
			repeat ($urandom_range(2, 1)) m[$urandom_range(63, 0)] = 1'b1;
		else
			m = {$urandom, $urandom};
		return m;
	endfunction

	function automatic logic [COMP_W-1:0] pick_comp();
		return COMP_W'(($urandom_range(1, 0)) ? $urandom_range(7, 0) : $urandom_range(63, 0));
	endfunction

	task automatic random_command();
		int r;
		int r2;
		int start;
		r = $urandom_range(99, 0);
		if (r < 12) begin
			send_command(KIND_ALLOC, ID_W'($urandom_range(4095, 0)),
				COMP_W'($urandom_range(63, 0)), {$urandom, $urandom});
		end else if (r < 37) begin
			send_command(KIND_SET, pick_entity(), pick_comp(), {$urandom, $urandom});
		end else if (r < 52) begin
			send_command(KIND_CLEAR, pick_entity(), pick_comp(), {$urandom, $urandom});
		end else if (r < 57) begin
			send_command(KIND_DESTROY, pick_entity(), COMP_W'($urandom_range(63, 0)),
				{$urandom, $urandom});
		end else if (r < 75) begin
			send_command(KIND_HAS, pick_entity(), COMP_W'($urandom_range(63, 0)), pick_mask());
		end else if (r < 95) begin
			r2 = $urandom_range(99, 0);
			if (r2 < 50)
				start = ((next_guess > WINDOW) ? next_guess - WINDOW : 0)
					+ $urandom_range(WINDOW, 0);
			else if (r2 < 70)
				start = 0;
			else if (r2 < 90)
				start = $urandom_range(next_guess, 0);
			else
				start = $urandom_range(NUM_ENTITIES - 1, 0);
			if (start > NUM_ENTITIES - 1)
				start = NUM_ENTITIES - 1;
			send_command(KIND_QUERY, ID_W'(start), COMP_W'($urandom_range(63, 0)), pick_mask());
		end else if ($urandom_range(1, 0)) begin
			send_command($urandom_range(1, 0) ? KIND_SPARE_A : KIND_SPARE_B,
				ID_W'($urandom_range(4095, 0)), COMP_W'($urandom_range(63, 0)),
				{$urandom, $urandom});
		end else begin
			send_command(KIND_W'($urandom_range(7, 0)), ID_W'($urandom_range(4095, 0)),
				COMP_W'($urandom_range(63, 0)), {$urandom, $urandom});
		end
	endtask

	task automatic run_random(input int count, input int sender_pct, input int receiver_pct);
		snd_idle = sender_pct;
		rcv_idle = receiver_pct;
		repeat (count) random_command();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// low and high ids, empty and full masks, misses and spare kinds
		send_command(KIND_QUERY, 0, 0, '0);
		send_command(KIND_QUERY, ID_W'(FIRST_ID), 0, '0);
		send_command(KIND_HAS, 0, 0, '0);
		send_command(KIND_SET, 0, 63, '0);
		send_command(KIND_ALLOC, 0, 0, '0);
		send_command(KIND_ALLOC, 4095, 63, '1);
		send_command(KIND_SET, ID_W'(FIRST_ID), 0, '0);
		send_command(KIND_SET, ID_W'(FIRST_ID), 63, '0);
		send_command(KIND_SET, ID_W'(FIRST_ID + 1), 31, '0);
		send_command(KIND_HAS, ID_W'(FIRST_ID), 0, 64'h8000_0000_0000_0001);
		send_command(KIND_HAS, ID_W'(FIRST_ID), 0, '1);
		send_command(KIND_CLEAR, ID_W'(FIRST_ID), 63, '0);
		send_command(KIND_CLEAR, ID_W'(FIRST_ID), 5, '0);
		send_command(KIND_QUERY, 0, 0, 64'h0000_0000_8000_0000);
		send_command(KIND_QUERY, 0, 0, 64'h8000_0000_0000_0000);
		send_command(KIND_QUERY, ID_W'(FIRST_ID + 2), 0, '0);
		send_command(KIND_QUERY, 4095, 0, '0);
		send_command(KIND_DESTROY, ID_W'(FIRST_ID + 1), 0, '0);
		send_command(KIND_HAS, ID_W'(FIRST_ID + 1), 0, '0);
		send_command(KIND_SPARE_A, 4095, 63, '1);
		send_command(KIND_SPARE_B, 0, 0, '0);
		send_command(KIND_SET, 4095, 63, '0);
		send_command(KIND_HAS, 4095, 0, '1);
		send_command(KIND_DESTROY, 0, 0, '1);

		run_random(300, 35, 45);
		run_random(300, 45, 35);
		run_random(280, 0, 0);
		s_axis_tvalid <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Summary: %0d commands (%0d find-next), %0d results checked, %0d hits,",
			sent, queries_sent, checked, hits);
		$display("         %0d table-full replies, idle mixes 35/45, 45/35 and none", fulls);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("timeout: %0d commands sent, %0d results outstanding", sent, pending);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/cmt_pkg.sv
rtl/core/cmt_ram.sv
rtl/core/component_mask_table.sv
rtl/core/cmt_checker.sv
verif/component_mask_table_checker.sv
verif/testbench.sv
